/* rtl/core/rtt_pkg.sv */
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants for the rigid adjoint twist transform
// Request/result payloads, command codes, register indexes, datapath widths.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // command codes
  localparam logic [1:0] CMD_ADJ = 2'd0;  // adjoint
  localparam logic [1:0] CMD_INV = 2'd1;  // inverse adjoint
  localparam logic [1:0] CMD_TRN = 2'd2;  // transposed adjoint
  localparam logic [1:0] CMD_NUL = 2'd3;  // no map, zero result

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_ROW1 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_ROW2 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_ROW3 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANS_X  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANS_Y  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANS_Z  = 3'd5;

  localparam int unsigned ROW_W = 54;
  localparam int unsigned ROT_W = 18;  // Q1.16 signed
  localparam int unsigned VAL_W = 32;  // Q16.16 signed

  localparam logic [ROW_W-1:0] ROT_ROW1_RST = 54'd65536;
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = 54'd17179869184;
  localparam logic [ROW_W-1:0] ROT_ROW3_RST = 54'd4503599627370496;

  // datapath widths
  localparam int unsigned PROD_W = ROT_W + VAL_W;      // 50
  localparam int unsigned CROSS_W = PROD_W + 1;        // 51, entries of p^ R
  localparam int unsigned SPLIT_W = 17;                // low slice of a cross entry
  localparam int unsigned KH_W = CROSS_W - SPLIT_W + VAL_W;  // 66
  localparam int unsigned KL_W = SPLIT_W + 1 + VAL_W;        // 50
  localparam int unsigned SUM_W = PROD_W + 2;          // 52
  localparam int unsigned ACC_W = 88;                  // full 48-fraction-bit sum

  // pipeline depth from request accept to result strobe
  localparam int unsigned LATENCY = 5;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [VAL_W-1:0]  lin_x;
    logic signed [VAL_W-1:0]  lin_y;
    logic signed [VAL_W-1:0]  lin_z;
    logic signed [VAL_W-1:0]  ang_x;
    logic signed [VAL_W-1:0]  ang_y;
    logic signed [VAL_W-1:0]  ang_z;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_lin_x;
    logic signed [VAL_W-1:0]  out_lin_y;
    logic signed [VAL_W-1:0]  out_lin_z;
    logic signed [VAL_W-1:0]  out_ang_x;
    logic signed [VAL_W-1:0]  out_ang_y;
    logic signed [VAL_W-1:0]  out_ang_z;
    logic                     saturated;
  } res_t;

endpackage

/* rtl/core/rigid_adjoint_twist_transform_unit.sv */
// ----------------------------------------------------------------------------
// rigid_adjoint_twist_transform_unit: SE(3) adjoint applied to a twist
// Fixed-point adjoint, inverse adjoint and transposed adjoint of a stored pose.
// ----------------------------------------------------------------------------
// Usage:
//   Pose (R rows in Q1.16, p in Q16.16) is loaded over the config channel
//   (cfg_valid_i/cfg_ready_o, cfg_addr_i, cfg_data_i); cfg_ready_o is always
//   high. Write the pose only while no request is in flight.
//   A request (req_i) is taken on a clock edge with start_i high and busy_o
//   low; busy_o stays low, so one request per cycle is taken.
//   Each request gives one result on res_o, flagged by valid_o for a single
//   cycle, once it has passed the five register stages below. Throughput:
//   1 request/cycle.
//   The five register stages are: products of the inputs with R and of p with
//   R, cross matrix p^R and row sums, cross matrix times twist (split into
//   two partial products), partial sum, then final add, round and saturate.
//   The receiver has no back-pressure; results cannot be held off.
//   Reset clears all stage valid bits (no result comes out of flushed work)
//   and sets R to the identity and p to zero.
// ----------------------------------------------------------------------------
module rigid_adjoint_twist_transform_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  rtt_pkg::req_t                     req_i,
  output logic                              valid_o,
  output rtt_pkg::res_t                     res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rtt_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [rtt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rtt_pkg::*;

  localparam int unsigned NXT [3] = '{1, 2, 0};
  localparam int unsigned PRV [3] = '{2, 0, 1};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'h8000_0000);

  // ---------------- configuration ----------------
  logic [ROW_W-1:0]        rot_q [3];
  logic signed [VAL_W-1:0] trans_q [3];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= ROT_ROW1_RST;
      rot_q[1]   <= ROT_ROW2_RST;
      rot_q[2]   <= ROT_ROW3_RST;
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_ROT_ROW1: rot_q[0]   <= cfg_data_i[ROW_W-1:0];
        CFG_ROT_ROW2: rot_q[1]   <= cfg_data_i[ROW_W-1:0];
        CFG_ROT_ROW3: rot_q[2]   <= cfg_data_i[ROW_W-1:0];
        CFG_TRANS_X:  trans_q[0] <= $signed(cfg_data_i[VAL_W-1:0]);
        CFG_TRANS_Y:  trans_q[1] <= $signed(cfg_data_i[VAL_W-1:0]);
        CFG_TRANS_Z:  trans_q[2] <= $signed(cfg_data_i[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  logic signed [ROT_W-1:0] rot [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = $signed(rot_q[i][ROT_W*j +: ROT_W]);
      end
    end
  end

  // ---------------- stage 1: products ----------------
  logic                    req_acc;
  logic signed [VAL_W-1:0] in_v [3];
  logic signed [VAL_W-1:0] in_w [3];
  logic signed [ROT_W-1:0] mat [3][3];

  logic                     s1_vld_q;
  logic [1:0]               s1_cmd_q;
  logic signed [VAL_W-1:0]  s1_y_q [3];
  logic signed [PROD_W-1:0] s1_cpos_q [3][3];
  logic signed [PROD_W-1:0] s1_cneg_q [3][3];
  logic signed [PROD_W-1:0] s1_mv_q [3][3];
  logic signed [PROD_W-1:0] s1_mw_q [3][3];

  assign req_acc = start_i & ~busy_o;

  always_comb begin
    in_v[0] = req_i.lin_x;
    in_v[1] = req_i.lin_y;
    in_v[2] = req_i.lin_z;
    in_w[0] = req_i.ang_x;
    in_w[1] = req_i.ang_y;
    in_w[2] = req_i.ang_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat[i][j] = (req_i.command == CMD_ADJ) ? rot[i][j] : rot[j][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= req_i.command;
    for (int i = 0; i < 3; i++) begin
      s1_y_q[i] <= (req_i.command == CMD_TRN) ? in_v[i] : in_w[i];
      for (int j = 0; j < 3; j++) begin
        // row i of p^ R: p[next]*R[prev][j] - p[prev]*R[next][j]
        s1_cpos_q[i][j] <= trans_q[NXT[i]] * rot[PRV[i]][j];
        s1_cneg_q[i][j] <= trans_q[PRV[i]] * rot[NXT[i]][j];
        s1_mv_q[i][j]   <= mat[i][j] * in_v[j];
        s1_mw_q[i][j]   <= mat[i][j] * in_w[j];
      end
    end
  end

  // ---------------- stage 2: cross matrix, row sums ----------------
  logic signed [CROSS_W-1:0] cross_m [3][3];

  logic                      s2_vld_q;
  logic [1:0]                s2_cmd_q;
  logic signed [VAL_W-1:0]   s2_y_q [3];
  logic signed [CROSS_W-1:0] s2_k_q [3][3];
  logic signed [SUM_W-1:0]   s2_lin_q [3];
  logic signed [SUM_W-1:0]   s2_ang_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cross_m[i][j] = CROSS_W'(s1_cpos_q[i][j]) - CROSS_W'(s1_cneg_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cmd_q <= s1_cmd_q;
    s2_y_q   <= s1_y_q;
    for (int i = 0; i < 3; i++) begin
      s2_lin_q[i] <= SUM_W'(s1_mv_q[i][0]) + SUM_W'(s1_mv_q[i][1])
                   + SUM_W'(s1_mv_q[i][2]);
      s2_ang_q[i] <= SUM_W'(s1_mw_q[i][0]) + SUM_W'(s1_mw_q[i][1])
                   + SUM_W'(s1_mw_q[i][2]);
      for (int j = 0; j < 3; j++) begin
        s2_k_q[i][j] <= (s1_cmd_q == CMD_ADJ) ? cross_m[i][j] : cross_m[j][i];
      end
    end
  end

  // ---------------- stage 3: cross times twist, split ----------------
  logic                    s3_vld_q;
  logic [1:0]              s3_cmd_q;
  logic signed [KH_W-1:0]  s3_kh_q [3][3];
  logic signed [KL_W-1:0]  s3_kl_q [3][3];
  logic signed [SUM_W-1:0] s3_lin_q [3];
  logic signed [SUM_W-1:0] s3_ang_q [3];

  always_ff @(posedge clk_i) begin
    s3_cmd_q <= s2_cmd_q;
    s3_lin_q <= s2_lin_q;
    s3_ang_q <= s2_ang_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_kh_q[i][j] <= $signed(s2_k_q[i][j][CROSS_W-1:SPLIT_W]) * s2_y_q[j];
        s3_kl_q[i][j] <= $signed({1'b0, s2_k_q[i][j][SPLIT_W-1:0]}) * s2_y_q[j];
      end
    end
  end

  // ---------------- stage 4: cross term sums ----------------
  logic                    s4_vld_q;
  logic [1:0]              s4_cmd_q;
  logic signed [ACC_W-1:0] s4_ky_q [3];
  logic signed [SUM_W-1:0] s4_lin_q [3];
  logic signed [SUM_W-1:0] s4_ang_q [3];

  always_ff @(posedge clk_i) begin
    s4_cmd_q <= s3_cmd_q;
    s4_lin_q <= s3_lin_q;
    s4_ang_q <= s3_ang_q;
    for (int i = 0; i < 3; i++) begin
      s4_ky_q[i] <= (ACC_W'(s3_kh_q[i][0]) <<< SPLIT_W) + ACC_W'(s3_kl_q[i][0])
                  + (ACC_W'(s3_kh_q[i][1]) <<< SPLIT_W) + ACC_W'(s3_kl_q[i][1])
                  + (ACC_W'(s3_kh_q[i][2]) <<< SPLIT_W) + ACC_W'(s3_kl_q[i][2]);
    end
  end

  // ---------------- stage 5: final add, round, saturate ----------------
  logic signed [ACC_W-1:0] tot_lin [3];
  logic signed [ACC_W-1:0] tot_ang [3];
  logic [VAL_W-1:0]        rnd_lin [3];
  logic [VAL_W-1:0]        rnd_ang [3];
  logic [5:0]              clip;
  res_t                    res_d;
  res_t                    res_q;
  logic                    res_vld_q;

  // ties go up: add one half, keep bits above the 32 dropped fraction bits
  function automatic logic [VAL_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] r;
    logic             ovf;
    r   = acc + HALF;
    ovf = !((&r[ACC_W-1:63]) || !(|r[ACC_W-1:63]));
    if (ovf) begin
      return {1'b1, r[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    return {1'b0, r[63:32]};
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot_lin[i] = (ACC_W'(s4_lin_q[i]) <<< 16)
                 + ((s4_cmd_q != CMD_TRN) ? s4_ky_q[i] : '0);
      tot_ang[i] = (ACC_W'(s4_ang_q[i]) <<< 16)
                 + ((s4_cmd_q == CMD_TRN) ? s4_ky_q[i] : '0);
      {clip[i], rnd_lin[i]}     = round_sat(tot_lin[i]);
      {clip[3 + i], rnd_ang[i]} = round_sat(tot_ang[i]);
    end
    if (s4_cmd_q == CMD_NUL) begin
      res_d = '0;
    end else begin
      res_d.out_lin_x = $signed(rnd_lin[0]);
      res_d.out_lin_y = $signed(rnd_lin[1]);
      res_d.out_lin_z = $signed(rnd_lin[2]);
      res_d.out_ang_x = $signed(rnd_ang[0]);
      res_d.out_ang_y = $signed(rnd_ang[1]);
      res_d.out_ang_z = $signed(rnd_ang[2]);
      res_d.saturated = |clip;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= req_acc;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      res_vld_q <= s4_vld_q;
    end
  end

  assign valid_o = res_vld_q;
  assign res_o   = res_q;

endmodule

/* rtl/core/rtt_checker.sv */
// ----------------------------------------------------------------------------
// rtt_checker: port-level checks for the rigid adjoint twist transform
// Latency, zero result for the unused command, saturation flag consistency.
// ----------------------------------------------------------------------------
module rtt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input rtt_pkg::req_t req_i,
  input logic          valid_o,
  input rtt_pkg::res_t res_o
);
  import rtt_pkg::*;

  logic [LATENCY-1:0] acc_q;
  logic [LATENCY-1:0] nul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      nul_q <= '0;
    end else begin
      acc_q <= {acc_q[LATENCY-2:0], start_i & ~busy_o};
      nul_q <= {nul_q[LATENCY-2:0], req_i.command == CMD_NUL};
    end
  end

  // every accepted request yields exactly one strobe, fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == acc_q[LATENCY-1])
    else $error("result strobe does not match request accept");

  a_null_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && nul_q[LATENCY-1] |-> res_o == '0)
    else $error("unused command gave a nonzero result");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.saturated |->
      res_o.out_lin_x == 32'sh7FFF_FFFF || res_o.out_lin_x == 32'sh8000_0000 ||
      res_o.out_lin_y == 32'sh7FFF_FFFF || res_o.out_lin_y == 32'sh8000_0000 ||
      res_o.out_lin_z == 32'sh7FFF_FFFF || res_o.out_lin_z == 32'sh8000_0000 ||
      res_o.out_ang_x == 32'sh7FFF_FFFF || res_o.out_ang_x == 32'sh8000_0000 ||
      res_o.out_ang_y == 32'sh7FFF_FFFF || res_o.out_ang_y == 32'sh8000_0000 ||
      res_o.out_ang_z == 32'sh7FFF_FFFF || res_o.out_ang_z == 32'sh8000_0000)
    else $error("saturated flag set without a clipped component");

endmodule

bind rigid_adjoint_twist_transform_unit rtt_checker u_rtt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .valid_o (valid_o),
  .res_o   (res_o)
);
